// File: rtl/new_target_gaze_angles_defines.svh
// ---------------------------------------------------------------------------
// new_target_gaze_angles_defines.svh
// Assertion macros shared by the gaze angle checker.
// ---------------------------------------------------------------------------
`ifndef NEW_TARGET_GAZE_ANGLES_DEFINES_SVH
`define NEW_TARGET_GAZE_ANGLES_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define GTA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GTA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/gta_pkg.sv
// ---------------------------------------------------------------------------
// gta_pkg
// Types, constants and the arctangent table of the gaze angle block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gta_pkg;

	localparam int COORD_BITS      = 16;
	localparam int COUNT_BITS      = 5;
	localparam int ANGLE_BITS      = 16;
	localparam int HOLD_BITS       = 8;
	localparam int ANGLE_FRAC_BITS = 7;
	localparam int CORDIC_STEPS    = 20;
	localparam int STEP_BITS       = $clog2(CORDIC_STEPS);
	localparam int ZFRAC           = 20;
	localparam int GUARD           = 24;
	localparam int XY_BITS         = COORD_BITS + GUARD + 4;
	localparam int Z_BITS          = 29;
	localparam int TAB_BITS        = 27;
	localparam int RND_SHIFT       = ZFRAC - ANGLE_FRAC_BITS;
	localparam int IN_TDATA_BITS   = 56;
	localparam int OUT_TDATA_BITS  = 40;

	localparam logic [HOLD_BITS-1:0]  HOLD_RESET  = HOLD_BITS'(50);
	localparam logic [ANGLE_BITS-1:0] ANGLE_FULL  = ANGLE_BITS'(90 << ANGLE_FRAC_BITS);
	localparam logic [ANGLE_BITS-1:0] PAN_BASE    = ANGLE_BITS'(180 << ANGLE_FRAC_BITS);
	localparam logic [ANGLE_BITS-1:0] TILT_BASE   = ANGLE_BITS'(270 << ANGLE_FRAC_BITS);
	localparam logic [ANGLE_BITS-1:0] ANGLE_RESET = ANGLE_BITS'(180 << ANGLE_FRAC_BITS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ITER,
		ST_COMMIT
	} gta_state_t;

	typedef struct packed {
		logic                 load;
		logic                 iter;
		logic [STEP_BITS-1:0] idx;
		logic                 commit;
	} gta_cmd_t;

	typedef struct packed {
		logic active;
		logic out_free;
	} gta_status_t;

	// atan(2^-i) in degrees, scaled by 2^ZFRAC
	function automatic logic [TAB_BITS-1:0] atan_tab(input logic [STEP_BITS-1:0] i);
		logic [TAB_BITS-1:0] v;
		unique case (i)
			5'd0:    v = TAB_BITS'(47185920);
			5'd1:    v = TAB_BITS'(27855475);
			5'd2:    v = TAB_BITS'(14718068);
			5'd3:    v = TAB_BITS'(7471121);
			5'd4:    v = TAB_BITS'(3750058);
			5'd5:    v = TAB_BITS'(1876857);
			5'd6:    v = TAB_BITS'(938658);
			5'd7:    v = TAB_BITS'(469357);
			5'd8:    v = TAB_BITS'(234682);
			5'd9:    v = TAB_BITS'(117342);
			5'd10:   v = TAB_BITS'(58671);
			5'd11:   v = TAB_BITS'(29335);
			5'd12:   v = TAB_BITS'(14668);
			5'd13:   v = TAB_BITS'(7334);
			5'd14:   v = TAB_BITS'(3667);
			5'd15:   v = TAB_BITS'(1833);
			5'd16:   v = TAB_BITS'(917);
			5'd17:   v = TAB_BITS'(458);
			5'd18:   v = TAB_BITS'(229);
			5'd19:   v = TAB_BITS'(115);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/new_target_gaze_angles.sv
// ---------------------------------------------------------------------------
// new_target_gaze_angles
// Pan and tilt gaze angles toward the newest person, held after a count change.
// ---------------------------------------------------------------------------
// Usage:
//   s_* channel: one transaction per tick with person_count and x, y, z.
//   m_* channel: one transaction per tick with pan_angle, tilt_angle, strength.
//   cfg_we/cfg_data: write hold_ticks while the block is idle.
// Sequence: with the hold active, the input transaction is loaded, the
//   lanes run 20 arctangent steps and a commit registers the result; with
//   the hold inactive, the commit state follows the load with no steps.
// Inputs: a new transaction is taken only after the previous commit is done.
//   The 20-step CORDIC iteration sets the rate with the hold active; the
//   pan and tilt lanes run side by side on the same step counter.
// Reset: hold counter and last count clear, hold_ticks returns to 50 and
//   both held angles return to 180 degrees; no output is valid.
// Stall: a result waits in the output register while m_tready is low; the
//   next input is still taken and computed, and its commit waits until the
//   output register frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module new_target_gaze_angles (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [gta_pkg::HOLD_BITS-1:0]         cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// person_count[4:0], person_x[20:5], person_y[36:21], person_z[52:37], zero
	input  logic [gta_pkg::IN_TDATA_BITS-1:0]     s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// pan_angle[15:0], tilt_angle[31:16], strength[32], zero
	output logic [gta_pkg::OUT_TDATA_BITS-1:0]    m_tdata
);
	import gta_pkg::*;

	gta_cmd_t              cmd;
	gta_status_t           status;
	logic [ANGLE_BITS-1:0] pan_angle;
	logic [ANGLE_BITS-1:0] tilt_angle;
	logic                  strength;

	gta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	gta_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.person_count (s_tdata[COUNT_BITS-1:0]),
		.person_x     (signed'(s_tdata[COUNT_BITS +: COORD_BITS])),
		.person_y     (signed'(s_tdata[COUNT_BITS + COORD_BITS +: COORD_BITS])),
		.person_z     (signed'(s_tdata[COUNT_BITS + 2*COORD_BITS +: COORD_BITS])),
		.cmd          (cmd),
		.status       (status),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.pan_angle    (pan_angle),
		.tilt_angle   (tilt_angle),
		.strength     (strength)
	);

	assign m_tdata = {(OUT_TDATA_BITS - 2*ANGLE_BITS - 1)'(0), strength, tilt_angle, pan_angle};

endmodule

// File: rtl/gta_ctrl.sv
// ---------------------------------------------------------------------------
// gta_ctrl
// Sequencer: accepts a transaction, steps the arctangent lanes while the hold is active, commits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gta_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  gta_pkg::gta_status_t status,
	output gta_pkg::gta_cmd_t    cmd
);
	import gta_pkg::*;

	gta_state_t           state_q;
	gta_state_t           state_d;
	logic [STEP_BITS-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ITER)
				step_q <= step_q + 1'b1;
			else
				step_q <= '0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = status.active ? ST_ITER : ST_COMMIT;
			end
			ST_ITER: begin
				if (step_q == STEP_BITS'(CORDIC_STEPS - 1))
					state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (status.out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.iter   = 1'b0;
		cmd.idx    = step_q;
		cmd.commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_ITER:   cmd.iter = 1'b1;
			ST_COMMIT: cmd.commit = status.out_free;
			default: ;
		endcase
	end

endmodule

// File: rtl/gta_cordic.sv
// ---------------------------------------------------------------------------
// gta_cordic
// One vectoring lane: signed atan(num/den) in degrees, one step per cycle while iter is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gta_cordic (
	input  logic                                 clk,
	input  logic                                 start,
	input  logic                                 iter,
	input  logic [gta_pkg::STEP_BITS-1:0]        idx,
	input  logic signed [gta_pkg::COORD_BITS-1:0] num,
	input  logic signed [gta_pkg::COORD_BITS-1:0] den,
	output logic signed [gta_pkg::ANGLE_BITS-1:0] angle
);
	import gta_pkg::*;

	logic signed [XY_BITS-1:0]   x_q;
	logic signed [XY_BITS-1:0]   y_q;
	logic signed [Z_BITS-1:0]    z_q;
	logic                        n_zero_q;
	logic                        d_zero_q;
	logic                        n_neg_q;
	logic                        flip_q;

	logic signed [COORD_BITS:0]  num_ext;
	logic signed [COORD_BITS:0]  den_ext;
	logic signed [COORD_BITS:0]  an;
	logic signed [COORD_BITS:0]  ad;
	logic signed [XY_BITS-1:0]   xs;
	logic signed [XY_BITS-1:0]   ys;
	logic signed [Z_BITS-1:0]    tab;
	logic [Z_BITS-1:0]           z_pos;
	logic [Z_BITS:0]             rnd;
	logic [Z_BITS:0]             a_wide;
	logic [ANGLE_BITS-1:0]       mag;

	assign num_ext = {num[COORD_BITS-1], num};
	assign den_ext = {den[COORD_BITS-1], den};
	assign an      = num_ext[COORD_BITS] ? -num_ext : num_ext;
	assign ad      = den_ext[COORD_BITS] ? -den_ext : den_ext;
	assign xs      = x_q >>> idx;
	assign ys      = y_q >>> idx;
	assign tab     = signed'(Z_BITS'(atan_tab(idx)));

	always_ff @(posedge clk) begin
		if (start) begin
			x_q      <= XY_BITS'(ad) <<< GUARD;
			y_q      <= XY_BITS'(an) <<< GUARD;
			z_q      <= '0;
			n_zero_q <= (num == '0);
			d_zero_q <= (den == '0);
			n_neg_q  <= num[COORD_BITS-1];
			flip_q   <= num[COORD_BITS-1] ^ den[COORD_BITS-1];
		end else if (iter) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + tab;
			end else if (y_q < 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - tab;
			end
		end
	end

	assign z_pos  = z_q[Z_BITS-1] ? '0 : z_q;
	assign rnd    = {1'b0, z_pos} + (Z_BITS+1)'(1 << (RND_SHIFT - 1));
	assign a_wide = rnd >> RND_SHIFT;
	assign mag    = (a_wide > (Z_BITS+1)'(ANGLE_FULL)) ? ANGLE_FULL : a_wide[ANGLE_BITS-1:0];

	always_comb begin
		if (n_zero_q)
			angle = '0;
		else if (d_zero_q)
			angle = n_neg_q ? signed'(ANGLE_BITS'(0) - ANGLE_FULL) : signed'(ANGLE_FULL);
		else
			angle = flip_q ? signed'(ANGLE_BITS'(0) - mag) : signed'(mag);
	end

endmodule

// File: rtl/gta_datapath.sv
// ---------------------------------------------------------------------------
// gta_datapath
// Hold counter, two arctangent lanes, held angles and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gta_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [gta_pkg::HOLD_BITS-1:0]         cfg_data,
	input  logic [gta_pkg::COUNT_BITS-1:0]        person_count,
	input  logic signed [gta_pkg::COORD_BITS-1:0] person_x,
	input  logic signed [gta_pkg::COORD_BITS-1:0] person_y,
	input  logic signed [gta_pkg::COORD_BITS-1:0] person_z,
	input  gta_pkg::gta_cmd_t                     cmd,
	output gta_pkg::gta_status_t                  status,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic [gta_pkg::ANGLE_BITS-1:0]        pan_angle,
	output logic [gta_pkg::ANGLE_BITS-1:0]        tilt_angle,
	output logic                                  strength
);
	import gta_pkg::*;

	logic [HOLD_BITS-1:0]         hold_ticks_q;
	logic [HOLD_BITS-1:0]         hold_q;
	logic [COUNT_BITS-1:0]        last_count_q;
	logic                         active_q;
	logic [ANGLE_BITS-1:0]        pan_q;
	logic [ANGLE_BITS-1:0]        tilt_q;
	logic                         strength_q;
	logic                         out_valid_q;

	logic [HOLD_BITS-1:0]         hold_dec;
	logic [HOLD_BITS-1:0]         hold_new;
	logic                         active;
	logic signed [ANGLE_BITS-1:0] pan_atan;
	logic signed [ANGLE_BITS-1:0] tilt_atan;

	assign hold_dec = (hold_q == '0) ? '0 : hold_q - 1'b1;
	assign hold_new = (person_count != last_count_q) ? hold_ticks_q : hold_dec;
	assign active   = (person_count != '0) && (hold_new != '0);

	assign status.active   = active;
	assign status.out_free = !out_valid_q || out_ready;

	gta_cordic u_pan_lane (
		.clk   (clk),
		.start (cmd.load),
		.iter  (cmd.iter),
		.idx   (cmd.idx),
		.num   (person_x),
		.den   (person_z),
		.angle (pan_atan)
	);

	gta_cordic u_tilt_lane (
		.clk   (clk),
		.start (cmd.load),
		.iter  (cmd.iter),
		.idx   (cmd.idx),
		.num   (person_y),
		.den   (person_z),
		.angle (tilt_atan)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= HOLD_RESET;
			hold_q       <= '0;
			last_count_q <= '0;
			active_q     <= 1'b0;
			pan_q        <= ANGLE_RESET;
			tilt_q       <= ANGLE_RESET;
			strength_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we)
				hold_ticks_q <= cfg_data;
			if (cmd.load) begin
				hold_q       <= active ? hold_new : '0;
				last_count_q <= person_count;
				active_q     <= active;
			end
			if (cmd.commit) begin
				if (active_q) begin
					pan_q  <= PAN_BASE - ANGLE_BITS'(pan_atan);
					tilt_q <= TILT_BASE + ANGLE_BITS'(tilt_atan);
				end
				strength_q  <= active_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign pan_angle  = pan_q;
	assign tilt_angle = tilt_q;
	assign strength   = strength_q;

endmodule

// File: rtl/gta_checker.sv
// ---------------------------------------------------------------------------
// gta_checker
// Port-level checks of the gaze angle block, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "new_target_gaze_angles_defines.svh"

module gta_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [gta_pkg::OUT_TDATA_BITS-1:0] m_tdata
);
	import gta_pkg::*;

	`GTA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
	`GTA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after accept")
	`GTA_ASSERT_NOW(a_commit_to_idle, $rose(m_tvalid), s_tready, "result raised while not idle")
	`GTA_ASSERT_NOW(a_angle_range, m_tvalid, (m_tdata[15:0] >= 16'd11520) && (m_tdata[15:0] <= 16'd34560) && (m_tdata[31:16] >= 16'd23040) && (m_tdata[31:16] <= 16'd46080), "angle out of range")

endmodule

bind new_target_gaze_angles gta_checker u_gta_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
